/* sv/rgb_to_hsv_converter_unit_defines.svh */
// Assertion helpers for the color converter checks.
// Each expects clk and arst_n in scope.
`ifndef RGB_TO_HSV_CONVERTER_UNIT_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_DEFINES_SVH

// same-cycle implication
`define RHC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RHC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/rgb2hsv_pkg.sv */
package rgb2hsv_pkg;

	// channel depth and hue fraction bits
	localparam int CHANNEL_BITS  = 8;
	localparam int HUE_FRAC_BITS = 6;

	// hue geometry in degrees
	localparam int DEG_SLOPE  = 60;
	localparam int DEG_SECTOR = 120;
	localparam int DEG_FULL   = 360;

	// beat field widths
	localparam int PIX_W = CHANNEL_BITS;
	localparam int HUE_W = $clog2(DEG_FULL << HUE_FRAC_BITS);
	localparam int SAT_W = CHANNEL_BITS;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [HUE_W-1:0] hue_t;
	typedef logic [SAT_W-1:0] sat_t;

	// dominant channel
	typedef enum logic [2:0] {
		SEC_RED   = 3'b001,
		SEC_GREEN = 3'b010,
		SEC_BLUE  = 3'b100
	} sector_t;

endpackage

/* sv/rgb2hsv_in_if.sv */
interface rgb2hsv_in_if;
	import rgb2hsv_pkg::*;

	logic valid;
	logic ready;
	pix_t red;
	pix_t green;
	pix_t blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);

endinterface

/* sv/rgb2hsv_out_if.sv */
interface rgb2hsv_out_if;
	import rgb2hsv_pkg::*;

	logic valid;
	logic ready;
	hue_t hue;
	sat_t saturation;
	sat_t brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink (input valid, input hue, input saturation, input brightness,
		output ready);

endinterface

/* sv/rgb_to_hsv_converter_unit.sv */
// Channel   Dir  Fields                          Beat
// rgb       in   red, green, blue                one RGB pixel
// hsv       out  hue, saturation, brightness     one HSV result
//
// One pixel taken per cycle unless hsv stalls; one result per pixel, in order.
// Stages in order: max/min, dividend prep, divider entry, the divider steps
// and the output register; the restoring divider for the hue resolves one
// quotient bit per pipeline stage.
// Reset clears only the stage valid bits; data registers are not reset.
// Each stage holds while it is full and the one after it cannot take its
// beat, so empty stages keep filling and rgb stays ready past bubbles.
module rgb_to_hsv_converter_unit (
	input  logic          clk,
	input  logic          arst_n,
	rgb2hsv_in_if.sink    rgb,
	rgb2hsv_out_if.source hsv
);
	import rgb2hsv_pkg::*;

	localparam int CB       = CHANNEL_BITS;
	localparam int HF       = HUE_FRAC_BITS;
	localparam int HUE_FULL = DEG_FULL << HF;
	localparam int QW       = $clog2(HUE_FULL);    // hue quotient bits
	localparam int DW       = CB + 1;              // hue divisor (2d) bits
	localparam int NW       = QW + DW;             // hue dividend bits
	localparam int SW       = NW + 1;              // signed dividend work width
	localparam int DS       = (QW > CB) ? QW : CB; // divider steps
	localparam int L        = DS + 4;              // stages in total

	// stage valid bits and load enables
	logic [L-1:0] vld_q;
	logic [L-1:0] vin;
	logic [L:0]   ld;

	assign ld[L] = hsv.ready;
	assign vin   = {vld_q[L-2:0], rgb.valid};

	for (genvar i = 0; i < L; i++) begin : g_ld
		assign ld[i] = !vld_q[i] || ld[i+1];
	end

	assign rgb.ready = ld[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < L; i++) begin
				if (ld[i]) begin
					vld_q[i] <= vin[i];
				end
			end
		end
	end

	// stage 1: max, min, sector and signed channel difference
	logic [CB-1:0]        r_c, g_c, b_c, mx_c, mn_c;
	logic signed [CB:0]   diff_c;
	sector_t              sec_c;
	logic [CB-1:0]        mx_s1, d_s1;
	logic signed [CB:0]   diff_s1;
	sector_t              sec_s1;

	assign r_c = CB'(rgb.red);
	assign g_c = CB'(rgb.green);
	assign b_c = CB'(rgb.blue);

	always_comb begin
		// ties go to red, then green
		if (r_c >= g_c && r_c >= b_c) begin
			sec_c  = SEC_RED;
			mx_c   = r_c;
			diff_c = {1'b0, g_c} - {1'b0, b_c};
		end else if (g_c >= b_c) begin
			sec_c  = SEC_GREEN;
			mx_c   = g_c;
			diff_c = {1'b0, b_c} - {1'b0, r_c};
		end else begin
			sec_c  = SEC_BLUE;
			mx_c   = b_c;
			diff_c = {1'b0, r_c} - {1'b0, g_c};
		end
		mn_c = r_c;
		if (g_c < mn_c) mn_c = g_c;
		if (b_c < mn_c) mn_c = b_c;
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			mx_s1   <= mx_c;
			d_s1    <= mx_c - mn_c;
			diff_s1 <= diff_c;
			sec_s1  <= sec_c;
		end
	end

	// stage 2: hue dividend terms, saturation dividend, divisors
	logic signed [SW-1:0] d_x, diff_x, off_c;
	logic signed [SW-1:0] base_s2, slope_s2, wrap_s2;
	logic [2*CB-1:0]      snum_s2;
	logic [DW-1:0]        hdiv_s2;
	logic [CB-1:0]        sdiv_s2, mx_s2;

	assign d_x    = SW'(d_s1);
	assign diff_x = SW'(diff_s1);

	always_comb begin
		case (sec_s1)
			SEC_RED:   off_c = '0;
			SEC_GREEN: off_c = d_x * SW'(2 * DEG_SECTOR);
			SEC_BLUE:  off_c = d_x * SW'(4 * DEG_SECTOR);
			default:   off_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			// doubled terms; adding d rounds to nearest after dividing by 2d
			base_s2  <= (off_c <<< HF) + d_x;
			slope_s2 <= (diff_x * SW'(2 * DEG_SLOPE)) <<< HF;
			wrap_s2  <= (d_x * SW'(2 * DEG_FULL)) <<< HF;
			snum_s2  <= {d_s1, {CB{1'b0}}} - {{CB{1'b0}}, d_s1};
			// zero divisors become one so grey and black give zero quotients
			hdiv_s2  <= (d_s1 == '0) ? DW'(1) : {d_s1, 1'b0};
			sdiv_s2  <= (mx_s1 == '0) ? CB'(1) : mx_s1;
			mx_s2    <= mx_s1;
		end
	end

	// divider pipeline: entry 0 holds the prepared dividends
	logic [DW-1:0] hrem_s [DS+1];
	logic [QW-1:0] hlo_s  [DS+1];
	logic [DW-1:0] hdiv_s [DS+1];
	logic [CB-1:0] srem_s [DS+1];
	logic [CB-1:0] slo_s  [DS+1];
	logic [CB-1:0] sdiv_s [DS+1];
	logic [CB-1:0] mx_s   [DS+1];

	logic signed [SW-1:0] num_c, numw_c;

	// negative sums only come from the red sector; a full turn is added
	assign num_c  = base_s2 + slope_s2;
	assign numw_c = num_c[SW-1] ? num_c + wrap_s2 : num_c;

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			hrem_s[0] <= numw_c[NW-1:QW];
			hlo_s[0]  <= numw_c[QW-1:0];
			hdiv_s[0] <= hdiv_s2;
			srem_s[0] <= snum_s2[2*CB-1:CB];
			slo_s[0]  <= snum_s2[CB-1:0];
			sdiv_s[0] <= sdiv_s2;
			mx_s[0]   <= mx_s2;
		end
	end

	// one restoring step per stage; quotient bits shift in from the bottom
	for (genvar k = 1; k <= DS; k++) begin : g_div
		logic [DW-1:0] hrem_n;
		logic [QW-1:0] hlo_n;
		logic [CB-1:0] srem_n;
		logic [CB-1:0] slo_n;

		if (k <= QW) begin : g_hue
			logic [DW:0] sh;
			logic        ge;
			assign sh     = {hrem_s[k-1], hlo_s[k-1][QW-1]};
			assign ge     = sh >= {1'b0, hdiv_s[k-1]};
			assign hrem_n = ge ? DW'(sh - {1'b0, hdiv_s[k-1]}) : DW'(sh);
			assign hlo_n  = {hlo_s[k-1][QW-2:0], ge};
		end else begin : g_hue_hold
			assign hrem_n = hrem_s[k-1];
			assign hlo_n  = hlo_s[k-1];
		end

		if (k <= CB) begin : g_sat
			logic [CB:0] sh;
			logic        ge;
			assign sh     = {srem_s[k-1], slo_s[k-1][CB-1]};
			assign ge     = sh >= {1'b0, sdiv_s[k-1]};
			assign srem_n = ge ? CB'(sh - {1'b0, sdiv_s[k-1]}) : CB'(sh);
			assign slo_n  = {slo_s[k-1][CB-2:0], ge};
		end else begin : g_sat_hold
			assign srem_n = srem_s[k-1];
			assign slo_n  = slo_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (ld[2+k]) begin
				hrem_s[k] <= hrem_n;
				hlo_s[k]  <= hlo_n;
				hdiv_s[k] <= hdiv_s[k-1];
				srem_s[k] <= srem_n;
				slo_s[k]  <= slo_n;
				sdiv_s[k] <= sdiv_s[k-1];
				mx_s[k]   <= mx_s[k-1];
			end
		end
	end

	// output register: a rounded full turn wraps to zero
	logic [QW-1:0] hue_sout;
	logic [CB-1:0] sat_sout, bri_sout;
	logic [QW-1:0] hq_c;

	assign hq_c = hlo_s[DS];

	always_ff @(posedge clk) begin
		if (ld[L-1]) begin
			hue_sout <= (hq_c >= QW'(HUE_FULL)) ? hq_c - QW'(HUE_FULL) : hq_c;
			sat_sout <= slo_s[DS];
			bri_sout <= mx_s[DS];
		end
	end

	assign hsv.valid      = vld_q[L-1];
	assign hsv.hue        = HUE_W'(hue_sout);
	assign hsv.saturation = SAT_W'(sat_sout);
	assign hsv.brightness = SAT_W'(bri_sout);

endmodule

/* sv/rgb2hsv_checker.sv */
`include "rgb_to_hsv_converter_unit_defines.svh"

module rgb2hsv_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input rgb2hsv_pkg::hue_t hue,
	input rgb2hsv_pkg::sat_t saturation,
	input rgb2hsv_pkg::sat_t brightness
);
	import rgb2hsv_pkg::*;

	// pixels taken but not yet delivered
	logic [7:0] occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			case ({in_valid && in_ready, out_valid && out_ready})
				2'b10:   occ_q <= occ_q + 8'd1;
				2'b01:   occ_q <= occ_q - 8'd1;
				default: occ_q <= occ_q;
			endcase
		end
	end

	`RHC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(hue) && $stable(saturation) && $stable(brightness),
		"result beat changed while stalled")

	`RHC_ASSERT_NOW(a_no_phantom, out_valid, occ_q != 8'd0,
		"result beat with no pixel in flight")

	`RHC_ASSERT_NOW(a_empty_ready, occ_q == 8'd0, in_ready,
		"empty pipeline refused a pixel")

	`RHC_ASSERT_NOW(a_black, out_valid && brightness == '0,
		saturation == '0 && hue == '0,
		"black pixel gave nonzero hue or saturation")

endmodule

bind rgb_to_hsv_converter_unit rgb2hsv_checker u_rgb2hsv_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (rgb.valid),
	.in_ready   (rgb.ready),
	.out_valid  (hsv.valid),
	.out_ready  (hsv.ready),
	.hue        (hsv.hue),
	.saturation (hsv.saturation),
	.brightness (hsv.brightness)
);
